FILE: rtl/ray_box_slab_test_unit_assert.svh
// Assertion helpers shared by the slab test modules.
// Each expects clk and rst_n in scope.
`ifndef RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH

// same-cycle implication
`define RBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rbs_pkg.sv
package rbs_pkg;

    localparam int NUM_REGS = 7;
    localparam int THR_BITS = 31;

    localparam logic [2:0] REG_BOX_MIN_X  = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z  = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X  = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y  = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z  = 3'd5;
    localparam logic [2:0] REG_ZERO_THR   = 3'd6;

    localparam logic [THR_BITS-1:0] THR_RESET = 31'd1;

    // per-ray classification handed from front to back
    typedef struct packed {
        logic [2:0] par;       // axis is treated as parallel
        logic       par_miss;  // origin outside a parallel slab
    } rbs_class_t;

endpackage

FILE: rtl/rbs_queue.sv
module rbs_queue
    import rbs_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         nonempty
);

`include "ray_box_slab_test_unit_assert.svh"

    logic [W-1:0] mem_reg [0:1];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign dout     = mem_reg[rp_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

    `RBS_ASSERT_IMP(a_q_no_overrun, full, !push, "queue pushed while full")
    `RBS_ASSERT_NXT(a_q_fill_count, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1,
        "queue count did not rise on push")

endmodule

FILE: rtl/rbs_front.sv
module rbs_front
    import rbs_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int PW         = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  origin_x,
    input  logic signed [COORD_BITS-1:0]  origin_y,
    input  logic signed [COORD_BITS-1:0]  origin_z,
    input  logic signed [COORD_BITS-1:0]  dir_x,
    input  logic signed [COORD_BITS-1:0]  dir_y,
    input  logic signed [COORD_BITS-1:0]  dir_z,
    input  logic [3*COORD_BITS-1:0]       box_lo,
    input  logic [3*COORD_BITS-1:0]       box_hi,
    input  logic [THR_BITS-1:0]           thr,
    output logic                          push,
    output logic [PW-1:0]                 pld,
    input  logic                          q_full
);

    localparam int CB = COORD_BITS;
    localparam int AW = 3*CB + 2;

    logic              vld_reg;
    logic [3*CB-1:0]   org_reg;
    logic [3*CB-1:0]   dir_reg;
    logic [2:0]        par;
    logic [2:0]        outside;
    logic [3*AW-1:0]   axes;
    rbs_class_t        cls;

    assign in_ready = !vld_reg || !q_full;
    assign push     = vld_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            org_reg <= {origin_z, origin_y, origin_x};
            dir_reg <= {dir_z, dir_y, dir_x};
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [CB-1:0] o;
        logic signed [CB-1:0] d;
        logic signed [CB-1:0] lo;
        logic signed [CB-1:0] hi;
        logic signed [CB:0]   dlo;
        logic signed [CB:0]   dhi;
        logic [CB-1:0]        dmag;
        logic [CB-1:0]        mlo;
        logic [CB-1:0]        mhi;

        assign o   = org_reg[a*CB +: CB];
        assign d   = dir_reg[a*CB +: CB];
        assign lo  = box_lo[a*CB +: CB];
        assign hi  = box_hi[a*CB +: CB];
        // exact slab differences, one bit wider
        assign dlo = {lo[CB-1], lo} - {o[CB-1], o};
        assign dhi = {hi[CB-1], hi} - {o[CB-1], o};
        assign dmag = d[CB-1] ? CB'(-d) : d;
        assign mlo  = dlo[CB] ? CB'(-dlo) : dlo[CB-1:0];
        assign mhi  = dhi[CB] ? CB'(-dhi) : dhi[CB-1:0];

        assign par[a]     = {{THR_BITS{1'b0}}, dmag} <= {{CB{1'b0}}, thr};
        assign outside[a] = (o < lo) || (o > hi);

        assign axes[a*AW +: AW] = {mlo, mhi, dmag,
                                   dlo[CB] ^ d[CB-1], dhi[CB] ^ d[CB-1]};
    end

    assign cls.par      = par;
    assign cls.par_miss = |(par & outside);
    assign pld          = {cls, axes};

endmodule

FILE: rtl/rbs_divider.sv
module rbs_divider
    import rbs_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [COORD_BITS-1:0]        num,
    input  logic [COORD_BITS-1:0]        den,
    input  logic                         neg,
    output logic signed [COORD_BITS-1:0] quo
);

    // one restoring step per quotient bit, then clamp and sign
    localparam int CB = COORD_BITS;
    localparam int QW = COORD_BITS + FRAC_BITS;

    logic [CB-1:0] rem_reg [0:QW-1];
    logic [CB-1:0] q_reg   [0:QW-1];
    logic          ovf_reg [0:QW-1];
    logic [CB-1:0] num_reg [0:QW-1];
    logic [CB-1:0] den_reg [0:QW-1];
    logic          neg_reg [0:QW-1];
    logic [CB-1:0] quo_reg;
    logic [CB-1:0] lim;
    logic [CB-1:0] sat;

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int P = QW - 1 - i;
        logic [CB-1:0] rem_in;
        logic [CB-1:0] q_in;
        logic          ovf_in;
        logic [CB-1:0] num_in;
        logic [CB-1:0] den_in;
        logic          neg_in;
        logic          bit_in;
        logic [CB:0]   sh;
        logic [CB:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign ovf_in = 1'b0;
            assign num_in = num;
            assign den_in = den;
            assign neg_in = neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        if (P >= FRAC_BITS)
        begin : g_bit
            assign bit_in = num_in[P-FRAC_BITS];
        end
        else
        begin : g_zero
            assign bit_in = 1'b0;
        end

        assign sh   = {rem_in, bit_in};
        assign ge   = sh >= {1'b0, den_in};
        assign diff = sh - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[CB-1:0] : sh[CB-1:0];
                q_reg[i]   <= {q_in[CB-2:0], ge};
                ovf_reg[i] <= ovf_in | q_in[CB-1];
                num_reg[i] <= num_in;
                den_reg[i] <= den_in;
                neg_reg[i] <= neg_in;
            end
        end
    end

    // negative side may reach one further
    assign lim = {1'b0, {(CB-1){1'b1}}} + CB'(neg_reg[QW-1]);
    assign sat = (ovf_reg[QW-1] || (q_reg[QW-1] > lim)) ? lim : q_reg[QW-1];

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= neg_reg[QW-1] ? CB'(-sat) : sat;
    end

    assign quo = quo_reg;

endmodule

FILE: rtl/rbs_back.sv
module rbs_back
    import rbs_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int PW         = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_nonempty,
    input  logic [PW-1:0] q_data,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          hit
);

`include "ray_box_slab_test_unit_assert.svh"

    localparam int CB  = COORD_BITS;
    localparam int AW  = 3*CB + 2;
    localparam int LAT = COORD_BITS + FRAC_BITS + 1;
    localparam logic signed [CB-1:0] Q_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] Q_MAX = {1'b0, {(CB-1){1'b1}}};

    logic                  adv;
    rbs_class_t            in_cls;
    logic [LAT-1:0]        vld_reg;
    rbs_class_t            cls_reg [0:LAT-1];
    logic signed [CB-1:0]  quo [0:5];

    logic                  sort_valid_reg;
    logic                  sort_pm_reg;
    logic signed [CB-1:0]  s_reg [0:2];
    logic signed [CB-1:0]  t_reg [0:2];
    logic signed [CB-1:0]  s_next [0:2];
    logic signed [CB-1:0]  t_next [0:2];

    logic                  mm_valid_reg;
    logic                  mm_pm_reg;
    logic signed [CB-1:0]  ent_reg;
    logic signed [CB-1:0]  ext_reg;
    logic signed [CB-1:0]  ent_a;
    logic signed [CB-1:0]  ext_a;
    logic signed [CB-1:0]  ent_next;
    logic signed [CB-1:0]  ext_next;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic                  hit_next;

    // whole back end moves together; it stops only on a held result
    assign adv    = !out_valid_reg || out_ready;
    assign pop    = adv && q_nonempty;
    assign in_cls = q_data[3*AW +: $bits(rbs_class_t)];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic [AW-1:0] f;
        assign f = q_data[a*AW +: AW];

        // f = {mag lo, mag hi, |dir|, neg lo, neg hi}
        rbs_divider #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_lo (
            .clk (clk),
            .en  (adv),
            .num (f[2*CB+2 +: CB]),
            .den (f[2 +: CB]),
            .neg (f[1]),
            .quo (quo[2*a])
        );

        rbs_divider #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_hi (
            .clk (clk),
            .en  (adv),
            .num (f[CB+2 +: CB]),
            .den (f[2 +: CB]),
            .neg (f[0]),
            .quo (quo[2*a+1])
        );

        always_comb
        begin
            if (cls_reg[LAT-1].par[a])
            begin
                s_next[a] = Q_MIN;
                t_next[a] = Q_MAX;
            end
            else if (quo[2*a] > quo[2*a+1])
            begin
                s_next[a] = quo[2*a+1];
                t_next[a] = quo[2*a];
            end
            else
            begin
                s_next[a] = quo[2*a];
                t_next[a] = quo[2*a+1];
            end
        end
    end

    always_comb
    begin
        ent_a    = (s_reg[0] > s_reg[1]) ? s_reg[0] : s_reg[1];
        ent_next = (ent_a > s_reg[2]) ? ent_a : s_reg[2];
        ext_a    = (t_reg[0] < t_reg[1]) ? t_reg[0] : t_reg[1];
        ext_next = (ext_a < t_reg[2]) ? ext_a : t_reg[2];
        hit_next = !mm_pm_reg && !ext_reg[CB-1] && !(ent_reg > ext_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            sort_valid_reg <= 1'b0;
            mm_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg        <= {vld_reg[LAT-2:0], q_nonempty};
            sort_valid_reg <= vld_reg[LAT-1];
            mm_valid_reg   <= sort_valid_reg;
            out_valid_reg  <= mm_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg[0] <= in_cls;
            for (int i = 1; i < LAT; i++)
                cls_reg[i] <= cls_reg[i-1];
            for (int a = 0; a < 3; a++)
            begin
                s_reg[a] <= s_next[a];
                t_reg[a] <= t_next[a];
            end
            sort_pm_reg <= cls_reg[LAT-1].par_miss;
            ent_reg     <= ent_next;
            ext_reg     <= ext_next;
            mm_pm_reg   <= sort_pm_reg;
            hit_reg     <= hit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    `RBS_ASSERT_NXT(a_b_freeze, out_valid_reg && !out_ready,
        out_valid_reg && $stable(hit_reg) && $stable(vld_reg), "back end moved while held")
    `RBS_ASSERT_NXT(a_b_div_drain, vld_reg[LAT-1] && adv, sort_valid_reg,
        "divider result lost before sort stage")

endmodule

FILE: rtl/ray_box_slab_test_unit.sv
// channel | dir | handshake              | transfer
// cfg     | in  | psel/penable/pready    | one register read or write (APB)
// in      | in  | in_valid/in_ready      | ray origin_x..z, dir_x..z
// out     | out | out_valid/out_ready    | hit
//
// One ray per cycle sustained while out_ready keeps the back end moving; the latency is
// set by the restoring divider pipelines, one stage per quotient bit.
// Front, 2-entry queue and back stall independently; a held result freezes only the back.
// rst_n clears all valid state; the box resets to zero, the threshold to one.
module ray_box_slab_test_unit
    import rbs_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [((COORD_BITS > 32) ? 6 : 5)-1:0]   paddr,
    input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                                     pready,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [COORD_BITS-1:0]             origin_x,
    input  logic signed [COORD_BITS-1:0]             origin_y,
    input  logic signed [COORD_BITS-1:0]             origin_z,
    input  logic signed [COORD_BITS-1:0]             dir_x,
    input  logic signed [COORD_BITS-1:0]             dir_y,
    input  logic signed [COORD_BITS-1:0]             dir_z,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     hit
);

    localparam int CB = COORD_BITS;
    localparam int DW = (COORD_BITS > 32) ? 64 : 32;
    localparam int AB = (COORD_BITS > 32) ? 6 : 5;
    localparam int AL = (COORD_BITS > 32) ? 3 : 2;
    localparam int AW = 3*CB + 2;
    localparam int PW = 3*AW + $bits(rbs_class_t);

    logic [CB-1:0]       box_reg [0:5];
    logic [THR_BITS-1:0] thr_reg;
    logic [2:0]          idx;
    logic                wr;

    logic          push;
    logic [PW-1:0] f_pld;
    logic          q_full;
    logic          q_nonempty;
    logic [PW-1:0] q_data;
    logic          pop;

    assign pready = 1'b1;
    assign idx    = paddr[AB-1:AL];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                box_reg[i] <= '0;
            thr_reg <= THR_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_BOX_MIN_X, REG_BOX_MIN_Y, REG_BOX_MIN_Z,
                REG_BOX_MAX_X, REG_BOX_MAX_Y, REG_BOX_MAX_Z:
                    box_reg[idx] <= pwdata[CB-1:0];
                REG_ZERO_THR:
                    thr_reg <= pwdata[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BOX_MIN_X, REG_BOX_MIN_Y, REG_BOX_MIN_Z,
            REG_BOX_MAX_X, REG_BOX_MAX_Y, REG_BOX_MAX_Z:
                prdata = DW'($signed(box_reg[idx]));
            REG_ZERO_THR:
                prdata = DW'(thr_reg);
            default:
                prdata = '0;
        endcase
    end

    rbs_front #(.COORD_BITS(COORD_BITS), .PW(PW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .origin_z (origin_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .box_lo   ({box_reg[2], box_reg[1], box_reg[0]}),
        .box_hi   ({box_reg[5], box_reg[4], box_reg[3]}),
        .thr      (thr_reg),
        .push     (push),
        .pld      (f_pld),
        .q_full   (q_full)
    );

    rbs_queue #(.W(PW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (f_pld),
        .full     (q_full),
        .pop      (pop),
        .dout     (q_data),
        .nonempty (q_nonempty)
    );

    rbs_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .PW(PW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit)
    );

endmodule

FILE: test/ray_box_slab_test_unit_tb.sv
module ray_box_slab_test_unit_tb;
    import rbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 32;
    localparam int FB = 16;
    localparam int LATENCY = CB + FB + 5;
    localparam int N_RANDOM = 520;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        coord_t ox;
        coord_t oy;
        coord_t oz;
        coord_t dx;
        coord_t dy;
        coord_t dz;
    } ray_t;

    // directed row: ray, expected hit where obvious (known = 0 means use predictor)
    typedef struct packed {
        ray_t ray;
        logic known;
        logic hit;
    } ray_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    coord_t origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
    logic out_valid;
    logic out_ready;
    logic hit;

    ray_box_slab_test_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
    );

    // local copy of the box and threshold
    coord_t box_lo [3];
    coord_t box_hi [3];
    logic [THR_BITS-1:0] zero_thr;

    logic expected_hits [$];
    int mismatches;
    int errors;
    int hold_off;      // receiver stall cycles requested by the stimulus
    logic stall_pattern;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic logic [63:0] magnitude(input coord_t v);
        logic signed [63:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // (lo - o) * 2^FB / d, truncated toward zero, saturated to the coordinate range
    function automatic logic signed [63:0] slab_quotient(input coord_t lo, input coord_t o,
                                                          input coord_t d);
        logic signed [63:0] diff;
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0] den;
        logic neg;
        logic [63:0] lim;
        diff = $signed({{32{lo[CB-1]}}, lo}) - $signed({{32{o[CB-1]}}, o});
        neg = (diff < 0) != d[CB-1];
        num = {64'd0, ((diff < 0) ? -diff : diff)} << FB;
        den = magnitude(d);
        q = num / {64'd0, den};
        lim = (64'd1 << (CB - 1)) - (neg ? 64'd0 : 64'd1);
        if (q > {64'd0, lim})
            q = {64'd0, lim};
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic predict_hit(input ray_t r);
        coord_t o [3];
        coord_t d [3];
        logic signed [63:0] entry, leave, s, t, tmp;
        logic ok;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        entry = 64'sh8000_0000_0000_0000;
        leave = 64'sh7FFF_FFFF_FFFF_FFFF;
        ok = 1'b1;
        for (int ax = 0; ax < 3; ax++)
        begin
            if (ok)
            begin
                if (magnitude(d[ax]) <= {33'd0, zero_thr})
                begin
                    if (o[ax] < box_lo[ax] || o[ax] > box_hi[ax])
                        ok = 1'b0;
                end
                else
                begin
                    s = slab_quotient(box_lo[ax], o[ax], d[ax]);
                    t = slab_quotient(box_hi[ax], o[ax], d[ax]);
                    if (s > t)
                    begin
                        tmp = s;
                        s = t;
                        t = tmp;
                    end
                    if (s > entry)
                        entry = s;
                    if (t < leave)
                        leave = t;
                    if (leave < 0 || entry > leave)
                        ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx < 3)
            box_lo[idx] = value;
        else if (idx < 6)
            box_hi[idx - 3] = value;
        else if (idx == REG_ZERO_THR)
            zero_thr = value[THR_BITS-1:0];
    endtask

    task automatic set_box(input coord_t lx, input coord_t ly, input coord_t lz,
                           input coord_t hx, input coord_t hy, input coord_t hz,
                           input logic [31:0] thr);
        apb_write(REG_BOX_MIN_X, lx);
        apb_write(REG_BOX_MIN_Y, ly);
        apb_write(REG_BOX_MIN_Z, lz);
        apb_write(REG_BOX_MAX_X, hx);
        apb_write(REG_BOX_MAX_Y, hy);
        apb_write(REG_BOX_MAX_Z, hz);
        apb_write(REG_ZERO_THR, thr);
    endtask

    // one ray transfer; valid stays high across back-to-back items
    task automatic send_ray(input ray_t r, input logic known, input logic want);
        in_valid <= 1'b1;
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
        do
            @(posedge clk);
        while (!in_ready);
        if (known && want != predict_hit(r))
        begin
            $display("directed row disagrees with predictor: %h", r);
            errors++;
        end
        expected_hits.push_back(predict_hit(r));
    endtask

    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
            2: return $signed($urandom_range(0, 8)) - 4;
            default: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        int m;
        m = $urandom_range(0, 9);
        // mostly rays near a unit-scale box, some wide noise
        if (m < 7)
        begin
            r.ox = rand_coord(1); r.oy = rand_coord(1); r.oz = rand_coord(1);
            r.dx = rand_coord($urandom_range(0, 5) == 0 ? 2 : 1);
            r.dy = rand_coord($urandom_range(0, 5) == 0 ? 2 : 1);
            r.dz = rand_coord($urandom_range(0, 5) == 0 ? 2 : 1);
        end
        else
        begin
            r.ox = rand_coord($urandom_range(0, 3)); r.oy = rand_coord($urandom_range(0, 3));
            r.oz = rand_coord($urandom_range(0, 3)); r.dx = rand_coord($urandom_range(0, 3));
            r.dy = rand_coord($urandom_range(0, 3)); r.dz = rand_coord($urandom_range(0, 3));
        end
        return r;
    endfunction

    localparam coord_t ONE = 32'sh0001_0000;
    localparam coord_t MAXC = 32'sh7FFF_FFFF;
    localparam coord_t MINC = 32'sh8000_0000;

    ray_row_t directed [] = '{
        // reset box is a point at the origin, threshold one lsb
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 1'b1},
        '{'{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 1'b0},
        // one-lsb directions count as parallel, origin off the point
        '{'{-32'sd2, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1}, 1'b1, 1'b0},
        '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC}, 1'b0, 1'b0},
        '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 1'b0, 1'b0},
        '{'{MINC, 32'sd0, 32'sd0, 32'sd2, 32'sd0, 32'sd0}, 1'b0, 1'b0},
        '{'{32'sd0, 32'sd0, 32'sd0, MAXC, MINC, 32'sd5}, 1'b0, 1'b0},
        '{'{-ONE, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0}, 1'b0, 1'b0}
    };

    ray_row_t directed_box [] = '{
        // box [-1,1]^3, threshold 0x100
        '{'{-3*ONE, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0}, 1'b1, 1'b1},
        '{'{3*ONE, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0}, 1'b1, 1'b0},
        '{'{32'sd0, 2*ONE, 32'sd0, ONE, 32'sd0, 32'sd0}, 1'b1, 1'b0},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 1'b1},
        '{'{-3*ONE, -3*ONE, -3*ONE, ONE, ONE, ONE}, 1'b1, 1'b1},
        '{'{-3*ONE, 3*ONE, 32'sd0, ONE, ONE, 32'sd0}, 1'b0, 1'b0},
        '{'{MINC, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0}, 1'b0, 1'b0},
        '{'{32'sd0, 32'sd0, MAXC, 32'sd0, 32'sd0, -32'sd257}, 1'b0, 1'b0},
        '{'{32'sd0, ONE, 32'sd0, 32'sd256, 32'sd0, -32'sd256}, 1'b1, 1'b1}
    };

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (stall_pattern)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected result transfer: hit=%b", hit);
                mismatches++;
            end
            else
            begin
                logic want;
                want = expected_hits.pop_front();
                if (hit !== want)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("hit mismatch: expected %b, got %b", want, hit);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("ray_box_slab_test_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        int burst;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        hold_off = 0;
        stall_pattern = 1'b0;
        mismatches = 0;
        errors = 0;
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = '0;
            box_hi[i] = '0;
        end
        zero_thr = THR_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_ray(directed[i].ray, directed[i].known, directed[i].hit);
        wait_drained();

        set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 32'h100);
        foreach (directed_box[i])
            send_ray(directed_box[i].ray, directed_box[i].known, directed_box[i].hit);
        wait_drained();

        // register extremes: full-range box, max thr: all but MINC dirs parallel
        set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC, 32'h7FFF_FFFF);
        send_ray('{MINC, MAXC, 32'sd0, MINC, MAXC, 32'sd0}, 1'b1, 1'b1);
        wait_drained();
        // inverted box on a parallel axis always misses
        apb_write(REG_BOX_MIN_X, 32'h0001_0000);
        apb_write(REG_BOX_MAX_X, 32'hFFFF_0000);
        send_ray('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 1'b0);
        wait_drained();
        apb_write(REG_ZERO_THR, 32'd0);
        send_ray('{32'sd0, 32'sd0, 32'sd0, ONE, 32'sd3, -32'sd7}, 1'b0, 1'b0);
        wait_drained();

        // long receiver hold-off while the sender keeps offering rays
        set_box(-2*ONE, -ONE, -3*ONE, 2*ONE, ONE, 3*ONE, 32'h10);
        hold_off <= 3 * LATENCY;
        for (int i = 0; i < 2 * LATENCY; i++)
            send_ray(rand_ray(), 1'b0, 1'b0);
        wait_drained();

        stall_pattern = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 1)
                set_box(rand_coord(1), rand_coord(1), rand_coord(1),
                        rand_coord(1), rand_coord(1), rand_coord(1), $urandom_range(0, 512));
            else if (phase == 2)
                set_box(rand_coord(0), rand_coord(0), rand_coord(0),
                        rand_coord(0), rand_coord(0), rand_coord(0), $urandom());
            else if (phase == 3)
                set_box(-ONE, -ONE, -ONE, 3*ONE, 3*ONE, 3*ONE, 32'd0);
            stall_pattern = (phase != 2);
            for (int n = 0; n < N_RANDOM / 4; n += burst)
            begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst; k++)
                    send_ray(rand_ray(), 1'b0, 1'b0);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 6));
            end
            wait_drained();
        end

        if (errors == 0)
            $display("ray_box_slab_test_unit_tb: PASS");
        else
            $display("ray_box_slab_test_unit_tb: FAIL");
        $finish;
    end

endmodule
